>>> rtl/core/thermistor_adc_to_temperature_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the thermistor ADC to temperature unit
// Same-cycle and next-cycle implication checks, clocked on clk, off in reset.
// ----------------------------------------------------------------------------
`ifndef THERMISTOR_ADC_TO_TEMPERATURE_UNIT_ASSERT_SVH
`define THERMISTOR_ADC_TO_TEMPERATURE_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TATU_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TATU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/tatu_pkg.sv
// ----------------------------------------------------------------------------
// Thermistor ADC to temperature unit package
// Widths, constants and the piecewise-linear segment table.
// ----------------------------------------------------------------------------
package tatu_pkg;

    localparam int SAMPLES_PER_READING = 10;
    localparam int ADC_BITS            = 10;
    localparam int VREF_MV             = 3300;

    localparam int ADC_W   = 10;
    localparam int SER_W   = 16;
    localparam int TEMP_W  = 13;
    localparam int RES_W   = 26;
    localparam int MV_W    = 12;
    localparam int SUM_W   = $clog2(SAMPLES_PER_READING * ((1 << ADC_BITS) - 1) + 1);
    localparam int CNT_W   = $clog2(SAMPLES_PER_READING + 1);
    localparam int NUM_W   = MV_W + SER_W;
    localparam int DVS_W   = 14;
    localparam int TD_W    = 24;
    localparam int BIT_W   = $clog2(NUM_W + 1);
    localparam int SEG_N   = 6;
    localparam int SEG_W   = 3;
    localparam int OHM_W   = 16;

    localparam logic [SER_W-1:0] SERIES_RESET = SER_W'(10000);

    typedef struct packed {
        logic [OHM_W-1:0]  lo;
        logic [OHM_W-1:0]  hi;
        logic [DVS_W-1:0]  k10;
        logic [TEMP_W-1:0] base;
    } seg_t;

    function automatic seg_t seg_at(input logic [SEG_W-1:0] idx);
        seg_t s;
        case (idx)
            3'd0:    s = '{lo: 16'd20310, hi: 16'd33970, k10: 14'd13660, base: 13'd0};
            3'd1:    s = '{lo: 16'd12570, hi: 16'd20310, k10: 14'd7740,  base: 13'd1000};
            3'd2:    s = '{lo: 16'd8034,  hi: 16'd12570, k10: 14'd4537,  base: 13'd2000};
            3'd3:    s = '{lo: 16'd5298,  hi: 16'd8034,  k10: 14'd2737,  base: 13'd3000};
            3'd4:    s = '{lo: 16'd3586,  hi: 16'd5298,  k10: 14'd1717,  base: 13'd4000};
            3'd5:    s = '{lo: 16'd2484,  hi: 16'd3586,  k10: 14'd1102,  base: 13'd5000};
            default: s = '{lo: 16'hFFFF,  hi: 16'd0,     k10: 14'd1,     base: 13'd0};
        endcase
        return s;
    endfunction

endpackage

>>> rtl/core/thermistor_adc_to_temperature_unit.sv
// ----------------------------------------------------------------------------
// Thermistor ADC to temperature unit
// Averages groups of ADC samples and maps the thermistor resistance to
// hundredths of a degree Celsius through six linear segments.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid/in_ready) takes one ADC sample per request.
//   Every tenth sample closes a group and produces one result request on the
//   output channel (out_valid/out_ready); other samples produce none.
//   The first nine samples of a group are taken one per cycle, even while the
//   previous group is still being converted. The tenth waits until the
//   converter is idle.
//   Conversion runs three divisions on one radix-2 restoring divider, one
//   quotient bit per cycle: for the average, the resistance and the
//   segment slope. The slope division is skipped when the resistance is
//   out of range.
//   The result sits in an output register; while the receiver stalls, the
//   next group is summed and converted, and waits in its last step.
//   series_ohms is written through cfg_we/cfg_wdata by the user, only while
//   the unit is idle; the unit does not enforce this. Reset clears the sum,
//   count and last temperature and sets series_ohms to 10000.
// ----------------------------------------------------------------------------
module thermistor_adc_to_temperature_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [tatu_pkg::ADC_W-1:0]  adc_sample,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [tatu_pkg::TEMP_W-1:0] temp_centi,
    output logic                        in_range,
    output logic [tatu_pkg::RES_W-1:0]  resistance_ohms,
    input  logic                        cfg_we,
    input  logic [tatu_pkg::SER_W-1:0]  cfg_wdata
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_AVG,
        S_MV,
        S_NUM,
        S_RES,
        S_SEG,
        S_TMP,
        S_DONE
    } state_t;

    localparam logic [tatu_pkg::CNT_W-1:0] CNT_LAST =
        tatu_pkg::CNT_W'(tatu_pkg::SAMPLES_PER_READING - 1);
    localparam int PROD_W = tatu_pkg::ADC_BITS + tatu_pkg::MV_W;
    localparam logic [tatu_pkg::TEMP_W-1:0] TEMP_TOP = tatu_pkg::TEMP_W'(6000);

    state_t                          state_reg, state_next;
    logic [tatu_pkg::SUM_W-1:0]      sum_reg, sum_next;
    logic [tatu_pkg::CNT_W-1:0]      cnt_reg, cnt_next;
    logic [tatu_pkg::TEMP_W-1:0]     last_temp_reg, last_temp_next;
    logic [tatu_pkg::SER_W-1:0]      series_reg, series_next;
    logic [tatu_pkg::NUM_W-1:0]      a_reg, a_next;
    logic [tatu_pkg::DVS_W-1:0]      rem_reg, rem_next;
    logic [tatu_pkg::DVS_W-1:0]      dvs_reg, dvs_next;
    logic [tatu_pkg::BIT_W-1:0]      bit_cnt_reg, bit_cnt_next;
    logic [tatu_pkg::MV_W-1:0]       mv_reg, mv_next;
    logic [tatu_pkg::RES_W-1:0]      r_reg, r_next;
    logic [tatu_pkg::TEMP_W-1:0]     base_reg, base_next;
    logic                            hit_reg, hit_next;
    logic                            out_valid_reg, out_valid_next;
    logic [tatu_pkg::TEMP_W-1:0]     temp_out_reg, temp_out_next;
    logic                            in_range_reg, in_range_next;
    logic [tatu_pkg::RES_W-1:0]      res_out_reg, res_out_next;

    logic                            take;
    logic                            group_close;
    logic                            div_off;
    logic [tatu_pkg::SUM_W-1:0]      sum_total;
    logic [tatu_pkg::DVS_W:0]        rem_sh;
    logic                            q_bit;
    logic [tatu_pkg::DVS_W-1:0]      rem_step;
    logic [tatu_pkg::NUM_W-1:0]      a_step;
    logic [PROD_W-1:0]               mv_prod;
    logic                            seg_found;
    tatu_pkg::seg_t                  seg_sel;
    tatu_pkg::seg_t                  seg_cur;
    logic [tatu_pkg::OHM_W-1:0]      seg_d;
    logic [tatu_pkg::TD_W-1:0]       seg_td;
    logic [tatu_pkg::TEMP_W-1:0]     temp_new;

    assign in_ready    = (cnt_reg != CNT_LAST) || (state_reg == S_IDLE);
    assign take        = in_valid && in_ready;
    assign group_close = take && (cnt_reg == CNT_LAST);
    assign div_off     = (state_reg == S_IDLE) || (state_reg == S_DONE) || (state_reg == S_SEG);
    assign sum_total = sum_reg + tatu_pkg::SUM_W'(adc_sample[tatu_pkg::ADC_BITS-1:0]);

    // One step of the restoring divider.
    assign rem_sh   = {rem_reg, a_reg[tatu_pkg::NUM_W-1]};
    assign q_bit    = rem_sh >= {1'b0, dvs_reg};
    assign rem_step = q_bit ? tatu_pkg::DVS_W'(rem_sh - {1'b0, dvs_reg})
                            : rem_sh[tatu_pkg::DVS_W-1:0];
    assign a_step   = {a_reg[tatu_pkg::NUM_W-2:0], q_bit};

    assign mv_prod  = PROD_W'(a_reg[tatu_pkg::ADC_BITS-1:0]) * PROD_W'(tatu_pkg::VREF_MV);
    assign temp_new = base_reg + a_reg[tatu_pkg::TEMP_W-1:0];

    always_comb
    begin
        seg_found = 1'b0;
        seg_sel   = tatu_pkg::seg_at(tatu_pkg::SEG_W'(0));
        for (int i = 0; i < tatu_pkg::SEG_N; i++)
        begin
            seg_cur = tatu_pkg::seg_at(tatu_pkg::SEG_W'(i));
            if (!seg_found
                && a_reg[tatu_pkg::RES_W-1:0] > tatu_pkg::RES_W'(seg_cur.lo)
                && a_reg[tatu_pkg::RES_W-1:0] <= tatu_pkg::RES_W'(seg_cur.hi))
            begin
                seg_found = 1'b1;
                seg_sel   = seg_cur;
            end
        end
        seg_d  = seg_sel.hi - a_reg[tatu_pkg::OHM_W-1:0];
        seg_td = tatu_pkg::TD_W'(seg_d) * tatu_pkg::TD_W'(1000);
    end

    always_comb
    begin
        state_next     = state_reg;
        sum_next       = sum_reg;
        cnt_next       = cnt_reg;
        last_temp_next = last_temp_reg;
        series_next    = cfg_we ? cfg_wdata : series_reg;
        a_next         = a_reg;
        rem_next       = rem_reg;
        dvs_next       = dvs_reg;
        bit_cnt_next   = bit_cnt_reg;
        mv_next        = mv_reg;
        r_next         = r_reg;
        base_next      = base_reg;
        hit_next       = hit_reg;
        out_valid_next = out_valid_reg && !out_ready;
        temp_out_next  = temp_out_reg;
        in_range_next  = in_range_reg;
        res_out_next   = res_out_reg;

        if (take)
        begin
            if (cnt_reg == CNT_LAST)
            begin
                sum_next = '0;
                cnt_next = '0;
            end
            else
            begin
                sum_next = sum_total;
                cnt_next = cnt_reg + 1'b1;
            end
        end

        case (state_reg)
            S_IDLE:
            begin
                if (group_close)
                begin
                    a_next       = {sum_total, {(tatu_pkg::NUM_W - tatu_pkg::SUM_W){1'b0}}};
                    rem_next     = '0;
                    dvs_next     = tatu_pkg::DVS_W'(tatu_pkg::SAMPLES_PER_READING);
                    bit_cnt_next = tatu_pkg::BIT_W'(tatu_pkg::SUM_W);
                    state_next   = S_AVG;
                end
            end
            S_AVG, S_RES, S_TMP:
            begin
                a_next       = a_step;
                rem_next     = rem_step;
                bit_cnt_next = bit_cnt_reg - 1'b1;
                if (bit_cnt_reg == tatu_pkg::BIT_W'(1))
                begin
                    case (state_reg)
                        S_AVG:   state_next = S_MV;
                        S_RES:   state_next = S_SEG;
                        default: state_next = S_DONE;
                    endcase
                end
            end
            S_MV:
            begin
                mv_next    = mv_prod[tatu_pkg::ADC_BITS +: tatu_pkg::MV_W];
                state_next = S_NUM;
            end
            S_NUM:
            begin
                a_next       = tatu_pkg::NUM_W'(mv_reg) * tatu_pkg::NUM_W'(series_reg);
                rem_next     = '0;
                dvs_next     = tatu_pkg::DVS_W'(tatu_pkg::VREF_MV) - tatu_pkg::DVS_W'(mv_reg);
                bit_cnt_next = tatu_pkg::BIT_W'(tatu_pkg::NUM_W);
                state_next   = S_RES;
            end
            S_SEG:
            begin
                r_next    = a_reg[tatu_pkg::RES_W-1:0];
                hit_next  = seg_found;
                base_next = seg_sel.base;
                if (seg_found)
                begin
                    a_next       = {seg_td, {(tatu_pkg::NUM_W - tatu_pkg::TD_W){1'b0}}};
                    rem_next     = '0;
                    dvs_next     = seg_sel.k10;
                    bit_cnt_next = tatu_pkg::BIT_W'(tatu_pkg::TD_W);
                    state_next   = S_TMP;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    in_range_next  = hit_reg;
                    res_out_next   = r_reg;
                    temp_out_next  = hit_reg ? temp_new : last_temp_reg;
                    if (hit_reg)
                    begin
                        last_temp_next = temp_new;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            sum_reg       <= '0;
            cnt_reg       <= '0;
            last_temp_reg <= '0;
            series_reg    <= tatu_pkg::SERIES_RESET;
            a_reg         <= '0;
            rem_reg       <= '0;
            dvs_reg       <= '0;
            bit_cnt_reg   <= '0;
            mv_reg        <= '0;
            r_reg         <= '0;
            base_reg      <= '0;
            hit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            temp_out_reg  <= '0;
            in_range_reg  <= 1'b0;
            res_out_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            sum_reg       <= sum_next;
            cnt_reg       <= cnt_next;
            last_temp_reg <= last_temp_next;
            series_reg    <= series_next;
            a_reg         <= a_next;
            rem_reg       <= rem_next;
            dvs_reg       <= dvs_next;
            bit_cnt_reg   <= bit_cnt_next;
            mv_reg        <= mv_next;
            r_reg         <= r_next;
            base_reg      <= base_next;
            hit_reg       <= hit_next;
            out_valid_reg <= out_valid_next;
            temp_out_reg  <= temp_out_next;
            in_range_reg  <= in_range_next;
            res_out_reg   <= res_out_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign temp_centi      = temp_out_reg;
    assign in_range        = in_range_reg;
    assign resistance_ohms = res_out_reg;

`include "thermistor_adc_to_temperature_unit_assert.svh"

    `TATU_ASSERT_NEXT(a_group_start, group_close, state_reg == S_AVG, "Group did not start")
    `TATU_ASSERT_NOW(a_div_idle, div_off, bit_cnt_reg == '0, "Divider count running while idle")
    `TATU_ASSERT_NOW(a_load_done, $rose(out_valid_reg), $past(state_reg) == S_DONE, "Stray result")
    `TATU_ASSERT_NOW(a_temp_span, in_range_reg, temp_out_reg < TEMP_TOP, "Temperature above 60 C")

endmodule
